// ----- design/rbim_pkg.sv -----
// Shared types and constants for the box IoU best-match block.
package rbim_pkg;

  localparam int CoordW = 12;
  localparam int IdW = 10;
  localparam int ScoreW = 18;
  localparam int LabelW = 8;
  localparam int FracW = 16;
  localparam int NumW = 25;
  localparam int DenW = 26;
  localparam int EntryW = IdW + 4 * CoordW;

  typedef enum logic [1:0] {
    KIND_CLEAR = 2'd0,
    KIND_LOAD  = 2'd1,
    KIND_QUERY = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    CFG_AREA_EN  = 2'd0,
    CFG_HORIZ_EN = 2'd1,
    CFG_VERT_EN  = 2'd2,
    CFG_THRESH   = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_GEOM,
    ST_PROD,
    ST_DEN,
    ST_AREA,
    ST_HORIZ,
    ST_VERT,
    ST_WAIT,
    ST_NEXT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;

endpackage

// ----- design/rbim_ram.sv -----
// Generic single-port RAM with registered read.
module rbim_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] addr,
  input  logic [Width-1:0]                            wdata,
  output logic [Width-1:0]                            rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ----- design/rbim_div.sv -----
// Restoring radix-2 divider giving a truncated Q1.16 fraction num/den.
module rbim_div
  import rbim_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [NumW-1:0] num,
  input  logic [DenW-1:0] den,
  output div_ctl_t        ctl,
  output logic [FracW:0]  quot
);
  localparam int CntW = $clog2(FracW + 2);
  localparam int RemW = DenW + 1;

  logic [RemW-1:0] rem_r, rem_nxt;
  logic [DenW-1:0] den_r, den_nxt;
  logic [FracW:0]  q_r, q_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt, done_r, done_nxt;
  logic [RemW-1:0] sh;

  always_comb begin
    rem_nxt = rem_r;
    den_nxt = den_r;
    q_nxt = q_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    sh = '0;
    if (start) begin
      den_nxt = den;
      q_nxt = '0;
      cnt_nxt = CntW'(FracW + 1);
      if (den == '0) begin
        rem_nxt = '0;
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        // num <= den, so the first step leaves quotient bit FracW
        rem_nxt = RemW'(num);
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      sh = rem_r;
      if (sh >= RemW'(den_r)) begin
        rem_nxt = (sh - RemW'(den_r)) << 1;
        q_nxt = {q_r[FracW-1:0], 1'b1};
      end else begin
        rem_nxt = sh << 1;
        q_nxt = {q_r[FracW-1:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    q_r <= q_nxt;
  end

  assign ctl = '{start: start, busy: busy_r, done: done_r};
  assign quot = q_r;
endmodule

// ----- design/roi_box_iou_best_match.sv -----
// Top level: cluster box table and sequenced IoU scoring with a shared divider.
// A query walks every stored box, one entry after another, and uses a single
// 17-step restoring divider for each enabled IoU term; the divider sets the pace.
// Clear, load and unused kinds give no result. The result appears for one cycle
// on out_valid; the receiver cannot stall it.
module roi_box_iou_best_match
  import rbim_pkg::*;
#(
  parameter int MAX_BOXES = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_kind,
  input  logic [IdW-1:0]    in_cluster_id,
  input  logic [CoordW-1:0] in_box_x,
  input  logic [CoordW-1:0] in_box_y,
  input  logic [CoordW-1:0] in_box_w,
  input  logic [CoordW-1:0] in_box_h,
  input  logic [LabelW-1:0] in_class_label,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [ScoreW-1:0] cfg_data,
  output logic              out_valid,
  output logic              out_matched,
  output logic [IdW-1:0]    out_match_id,
  output logic [ScoreW-1:0] out_best_score,
  output logic [LabelW-1:0] out_label_out,
  output logic              out_table_full
);
  localparam int AddrW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CntW = $clog2(MAX_BOXES + 1);
  localparam int EndW = CoordW + 1;

  logic area_en_r, horiz_en_r, vert_en_r;
  logic [ScoreW-1:0] thresh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      area_en_r <= 1'b0;
      horiz_en_r <= 1'b1;
      vert_en_r <= 1'b0;
      thresh_r <= ScoreW'(6554);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_AREA_EN:  area_en_r <= cfg_data[0];
        CFG_HORIZ_EN: horiz_en_r <= cfg_data[0];
        CFG_VERT_EN:  vert_en_r <= cfg_data[0];
        CFG_THRESH:   thresh_r <= cfg_data;
        default:      ;
      endcase
    end
  end

  state_t state_r, state_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic [CntW-1:0] idx_r, idx_nxt;
  logic ovf_r, ovf_nxt;
  logic [CoordW-1:0] qx_r, qy_r, qw_r, qh_r;
  logic [LabelW-1:0] lbl_r;
  logic [1:0] kind_r;
  logic [ScoreW-1:0] best_r, best_nxt, sum_r, sum_nxt;
  logic [IdW-1:0] bid_r, bid_nxt;
  logic have_r, have_nxt;
  logic ovx_ok_r, ovy_ok_r;
  logic [CoordW-1:0] ovx_r, ovy_r;
  logic [NumW-1:0] ov_r, pa_r, pb_r;
  logic [DenW-1:0] den_r;
  logic [1:0] term_r, term_nxt;

  logic ram_we;
  logic [AddrW-1:0] ram_addr;
  logic [EntryW-1:0] ram_wdata, ram_rdata;

  rbim_ram #(.Width(EntryW), .Depth(MAX_BOXES)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  logic [IdW-1:0] e_id;
  logic [CoordW-1:0] e_x, e_y, e_w, e_h;
  assign {e_id, e_x, e_y, e_w, e_h} = ram_rdata;

  logic div_start;
  logic [NumW-1:0] div_num;
  logic [DenW-1:0] div_den;
  div_ctl_t div_ctl;
  logic [FracW:0] div_q;

  rbim_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
    .ctl(div_ctl), .quot(div_q)
  );

  logic accept;
  assign accept = start && !busy;
  assign busy = (state_r != ST_IDLE);

  // geometry of the current pair
  logic [CoordW-1:0] lo_x, lo_y;
  logic [EndW-1:0] ea_x, eb_x, ea_y, eb_y, hi_x, hi_y;
  always_comb begin
    lo_x = (e_x > qx_r) ? e_x : qx_r;
    lo_y = (e_y > qy_r) ? e_y : qy_r;
    ea_x = EndW'(e_x) + EndW'(e_w);
    eb_x = EndW'(qx_r) + EndW'(qw_r);
    ea_y = EndW'(e_y) + EndW'(e_h);
    eb_y = EndW'(qy_r) + EndW'(qh_r);
    hi_x = (ea_x < eb_x) ? ea_x : eb_x;
    hi_y = (ea_y < eb_y) ? ea_y : eb_y;
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_GEOM) begin
      ovx_ok_r <= hi_x >= EndW'(lo_x);
      ovy_ok_r <= hi_y >= EndW'(lo_y);
      ovx_r <= CoordW'(hi_x - EndW'(lo_x));
      ovy_r <= CoordW'(hi_y - EndW'(lo_y));
    end
    if (state_r == ST_PROD) begin
      ov_r <= NumW'(ovx_r * ovy_r);
      pa_r <= NumW'(e_w * e_h);
      pb_r <= NumW'(qw_r * qh_r);
    end
    if (state_r == ST_DEN) begin
      den_r <= DenW'(pa_r) + DenW'(pb_r) - DenW'(ov_r);
    end
  end

  // state that runs term t (0 area, 1 horiz, 2 vert, 3 none: next box)
  function automatic state_t term_state(input logic [1:0] t);
    state_t s;
    s = ST_NEXT;
    case (t)
      2'd0: s = ST_AREA;
      2'd1: s = ST_HORIZ;
      2'd2: s = ST_VERT;
      default: s = ST_NEXT;
    endcase
    return s;
  endfunction

  logic [1:0] first_term, after_area, after_horiz;
  always_comb begin
    after_horiz = vert_en_r ? 2'd2 : 2'd3;
    after_area = horiz_en_r ? 2'd1 : after_horiz;
    first_term = area_en_r ? 2'd0 : after_area;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_READ;
      ST_READ: begin
        if (kind_t'(kind_r) != KIND_QUERY) state_nxt = ST_IDLE;
        else if (idx_r >= count_r) state_nxt = ST_DONE;
        else state_nxt = ST_GEOM;
      end
      ST_GEOM: state_nxt = ST_PROD;
      ST_PROD: state_nxt = ST_DEN;
      ST_DEN: begin
        if (!(ovx_ok_r && ovy_ok_r)) state_nxt = ST_NEXT;
        else state_nxt = term_state(first_term);
      end
      ST_AREA, ST_HORIZ, ST_VERT: state_nxt = ST_WAIT;
      ST_WAIT: if (div_ctl.done) state_nxt = term_state(term_r);
      ST_NEXT: state_nxt = ST_READ;
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    ovf_nxt = ovf_r;
    idx_nxt = idx_r;
    best_nxt = best_r;
    bid_nxt = bid_r;
    have_nxt = have_r;
    sum_nxt = sum_r;
    term_nxt = term_r;
    ram_we = 1'b0;
    ram_addr = AddrW'(idx_r);
    ram_wdata = {in_cluster_id, in_box_x, in_box_y, in_box_w, in_box_h};
    div_start = 1'b0;
    div_num = '0;
    div_den = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          idx_nxt = '0;
          best_nxt = '0;
          bid_nxt = '0;
          have_nxt = 1'b0;
          ram_addr = '0;
          unique case (kind_t'(in_kind))
            KIND_CLEAR: begin
              count_nxt = '0;
              ovf_nxt = 1'b0;
            end
            KIND_LOAD: begin
              if (count_r < CntW'(MAX_BOXES)) begin
                ram_we = 1'b1;
                ram_addr = AddrW'(count_r);
                count_nxt = count_r + 1'b1;
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_DEN: sum_nxt = '0;
      ST_AREA: begin
        div_start = 1'b1;
        div_num = ov_r;
        div_den = den_r;
        term_nxt = after_area;
      end
      ST_HORIZ: begin
        div_start = 1'b1;
        div_num = NumW'(ovx_r);
        div_den = DenW'(e_w) + DenW'(qw_r) - DenW'(ovx_r);
        term_nxt = after_horiz;
      end
      ST_VERT: begin
        div_start = 1'b1;
        div_num = NumW'(ovy_r);
        div_den = DenW'(e_h) + DenW'(qh_r) - DenW'(ovy_r);
        term_nxt = 2'd3;
      end
      ST_WAIT: if (div_ctl.done) sum_nxt = sum_r + ScoreW'(div_q);
      ST_NEXT: begin
        if (sum_r > best_r || (have_r && sum_r == best_r && e_id < bid_r)) begin
          best_nxt = sum_r;
          bid_nxt = e_id;
          have_nxt = 1'b1;
        end
        idx_nxt = idx_r + 1'b1;
        ram_addr = AddrW'(idx_r + 1'b1);
      end
      default: ;
    endcase
  end

  logic matched;
  assign matched = have_r && (best_r > thresh_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      ovf_r <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ovf_r <= ovf_nxt;
      out_valid <= (state_r == ST_DONE);
    end
    idx_r <= idx_nxt;
    best_r <= best_nxt;
    bid_r <= bid_nxt;
    have_r <= have_nxt;
    sum_r <= ST_NEXT == state_r ? '0 : sum_nxt;
    term_r <= term_nxt;
    if (accept) begin
      kind_r <= in_kind;
      qx_r <= in_box_x;
      qy_r <= in_box_y;
      qw_r <= in_box_w;
      qh_r <= in_box_h;
      lbl_r <= in_class_label;
    end
    if (state_r == ST_DONE) begin
      out_matched <= matched;
      out_match_id <= matched ? bid_r : '0;
      out_best_score <= best_r;
      out_label_out <= matched ? lbl_r : '0;
      out_table_full <= ovf_r;
    end
  end
endmodule

// ----- design/rbim_checker.sv -----
// Port-level checker for the box IoU best-match block, bound to the top level.
module rbim_checker
  import rbim_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input logic              out_matched,
  input logic [IdW-1:0]    out_match_id,
  input logic [LabelW-1:0] out_label_out
);
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("not busy after request");
  a_single_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result held two cycles");
  a_unmatched_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_matched |-> out_match_id == '0 && out_label_out == '0)
    else $error("unmatched result carries id or label");
  a_valid_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result without request");
endmodule

bind roi_box_iou_best_match rbim_checker u_rbim_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid),
  .out_matched(out_matched), .out_match_id(out_match_id),
  .out_label_out(out_label_out)
);

// ----- sim/testbench.sv -----
// Testbench for the box IoU best-match block: directed table, overflow and config cases, then random requests.
module testbench
  import rbim_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NBOX = 64;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_kind = KIND_NONE;
  logic [IdW-1:0] in_cluster_id = '0;
  logic [CoordW-1:0] in_box_x = '0, in_box_y = '0, in_box_w = '0, in_box_h = '0;
  logic [LabelW-1:0] in_class_label = '0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_AREA_EN;
  logic [ScoreW-1:0] cfg_data = '0;
  logic out_valid, out_matched, out_table_full;
  logic [IdW-1:0] out_match_id;
  logic [ScoreW-1:0] out_best_score;
  logic [LabelW-1:0] out_label_out;

  roi_box_iou_best_match dut (.*);

  always #5 clk = ~clk;

  typedef struct {
    kind_t kind;
    logic [IdW-1:0] id;
    logic [CoordW-1:0] x, y, w, h;
    logic [LabelW-1:0] label;
  } box_req_t;

  typedef struct {
    logic matched;
    logic [IdW-1:0] id;
    logic [ScoreW-1:0] score;
    logic [LabelW-1:0] label;
    logic full;
  } match_t;

  // directed row: request plus optional typed-in expectation
  typedef struct {
    box_req_t req;
    bit fixed;
    match_t want;
  } row_t;

  box_req_t stored[NBOX];
  int unsigned n_stored;
  bit overflow;
  bit en_area, en_horiz, en_vert;
  logic [ScoreW-1:0] threshold;

  match_t pending[$];
  int errors = 0;

  function automatic logic [31:0] q16_ratio(logic [63:0] num, logic [63:0] den);
    if (den == 0) return 32'd0;
    return 32'((num << 16) / den);
  endfunction

  function automatic logic [31:0] iou_score(box_req_t a, box_req_t b);
    logic [31:0] lx, ly, hx, hy, ox, oy, s;
    logic [63:0] ov;
    lx = (a.x > b.x) ? 32'(a.x) : 32'(b.x);
    ly = (a.y > b.y) ? 32'(a.y) : 32'(b.y);
    hx = (32'(a.x) + a.w < 32'(b.x) + b.w) ? 32'(a.x) + a.w : 32'(b.x) + b.w;
    hy = (32'(a.y) + a.h < 32'(b.y) + b.h) ? 32'(a.y) + a.h : 32'(b.y) + b.h;
    if (hx < lx || hy < ly) return 32'd0;
    ox = hx - lx;
    oy = hy - ly;
    s = 32'd0;
    if (en_area) begin
      ov = 64'(ox) * oy;
      s += q16_ratio(ov, 64'(a.w) * a.h + 64'(b.w) * b.h - ov);
    end
    if (en_horiz) s += q16_ratio(64'(ox), 64'(a.w) + b.w - ox);
    if (en_vert) s += q16_ratio(64'(oy), 64'(a.h) + b.h - oy);
    return s;
  endfunction

  // updates the box table; returns 1 with m filled when a result is due
  function automatic bit match_predict(box_req_t r, output match_t m);
    logic [31:0] best, s;
    logic [IdW-1:0] bid;
    bit have;
    m = '{default: '0};
    case (r.kind)
      KIND_CLEAR: begin
        n_stored = 0;
        overflow = 0;
        return 0;
      end
      KIND_LOAD: begin
        if (n_stored < NBOX) begin
          stored[n_stored] = r;
          n_stored++;
        end else begin
          overflow = 1;
        end
        return 0;
      end
      KIND_QUERY: begin
        best = 0;
        bid = 0;
        have = 0;
        for (int i = 0; i < n_stored; i++) begin
          s = iou_score(stored[i], r);
          if (s > best || (have && s == best && stored[i].id < bid)) begin
            best = s;
            bid = stored[i].id;
            have = 1;
          end
        end
        m.matched = have && best > threshold;
        m.id = m.matched ? bid : '0;
        m.score = best[ScoreW-1:0];
        m.label = m.matched ? r.label : '0;
        m.full = overflow;
        return 1;
      end
      default: return 0;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending.size() == 0) begin
        $display("unexpected result at %0t", $realtime);
        errors++;
      end else begin
        match_t w;
        w = pending.pop_front();
        if (out_matched !== w.matched) report_mismatch("matched", out_matched, w.matched);
        if (out_match_id !== w.id) report_mismatch("match_id", out_match_id, w.id);
        if (out_best_score !== w.score) report_mismatch("best_score", out_best_score, w.score);
        if (out_label_out !== w.label) report_mismatch("label_out", out_label_out, w.label);
        if (out_table_full !== w.full) report_mismatch("table_full", out_table_full, w.full);
      end
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [ScoreW-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_AREA_EN: en_area = val[0];
      CFG_HORIZ_EN: en_horiz = val[0];
      CFG_VERT_EN: en_vert = val[0];
      default: threshold = val;
    endcase
  endtask

  task automatic set_terms(bit a, bit h, bit v, logic [ScoreW-1:0] th);
    write_reg(CFG_AREA_EN, ScoreW'(a));
    write_reg(CFG_HORIZ_EN, ScoreW'(h));
    write_reg(CFG_VERT_EN, ScoreW'(v));
    write_reg(CFG_THRESH, th);
  endtask

  // sender: optional gap, then hold start until accepted
  task automatic send(box_req_t r, bit fixed, match_t want, int gap);
    match_t m;
    repeat (gap + 1) @(negedge clk);
    start <= 1'b1;
    in_kind <= r.kind;
    in_cluster_id <= r.id;
    in_box_x <= r.x;
    in_box_y <= r.y;
    in_box_w <= r.w;
    in_box_h <= r.h;
    in_class_label <= r.label;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (match_predict(r, m)) pending.insert(pending.size(), fixed ? want : m);
    @(negedge clk);
    start <= 1'b0;
  endtask

  task automatic drain();
    while (pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic box_req_t rand_req(kind_t k, bit tiny);
    box_req_t r;
    r.kind = k;
    r.id = 10'($urandom);
    r.label = 8'($urandom);
    if (tiny) begin
      r.x = 12'($urandom_range(0, 60));
      r.y = 12'($urandom_range(0, 60));
      r.w = 12'($urandom_range(0, 40));
      r.h = 12'($urandom_range(0, 40));
    end else begin
      r.x = 12'($urandom);
      r.y = 12'($urandom);
      r.w = 12'($urandom);
      r.h = 12'($urandom);
    end
    return r;
  endfunction

  row_t rows[$];
  match_t none = '{default: '0};

  function automatic row_t mk(kind_t k, int id, int x, int y, int w, int h, int lab,
                              bit fixed = 0, match_t want = '{default: '0});
    row_t r;
    r.req = '{kind: k, id: IdW'(id), x: CoordW'(x), y: CoordW'(y), w: CoordW'(w),
              h: CoordW'(h), label: LabelW'(lab)};
    r.fixed = fixed;
    r.want = want;
    return r;
  endfunction

  function automatic void add_row(row_t r);
    rows.insert(rows.size(), r);
  endfunction

  initial begin
    kind_t k;
    en_area = 0; en_horiz = 1; en_vert = 0; threshold = 6554;
    n_stored = 0; overflow = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part at reset settings
    add_row(mk(KIND_QUERY, 0, 0, 0, 0, 0, 8'hFF, 1, none));
    add_row(mk(KIND_LOAD, 7, 100, 100, 50, 50, 0));
    add_row(mk(KIND_LOAD, 3, 100, 100, 50, 50, 0));
    add_row(mk(KIND_QUERY, 0, 100, 100, 50, 50, 8'hA5, 1,
               '{matched: 1'b1, id: IdW'(3), score: ScoreW'(65536), label: 8'hA5,
                 full: 1'b0}));
    add_row(mk(KIND_QUERY, 0, 150, 150, 10, 10, 1, 0));
    add_row(mk(KIND_QUERY, 0, 3000, 3000, 5, 5, 2, 1, none));
    add_row(mk(KIND_NONE, 1023, 4095, 4095, 4095, 4095, 255));
    add_row(mk(KIND_LOAD, 1023, 4095, 4095, 4095, 4095, 0));
    add_row(mk(KIND_LOAD, 0, 0, 0, 0, 0, 0));
    add_row(mk(KIND_QUERY, 0, 4095, 4095, 4095, 4095, 255, 0));
    add_row(mk(KIND_QUERY, 0, 0, 0, 0, 0, 9, 0));
    add_row(mk(KIND_CLEAR, 0, 0, 0, 0, 0, 0));
    add_row(mk(KIND_QUERY, 0, 100, 100, 50, 50, 4, 1, none));
    foreach (rows[i]) send(rows[i].req, rows[i].fixed, rows[i].want, $urandom_range(0, 3));
    drain();

    // overflow: fill table beyond its depth
    set_terms(1, 1, 1, 0);
    for (int i = 0; i < NBOX + 2; i++)
      send(rand_req(KIND_LOAD, 1), 0, none, 0);
    send(rand_req(KIND_QUERY, 1), 0, none, 0);
    send(rand_req(KIND_CLEAR, 0), 0, none, 0);
    send(rand_req(KIND_QUERY, 1), 0, none, 0);
    drain();
    set_terms(0, 0, 0, 0);
    send(rand_req(KIND_LOAD, 1), 0, none, 0);
    send(rand_req(KIND_QUERY, 1), 0, none, 0);
    drain();
    set_terms(1, 1, 1, 196608);
    send(mk(KIND_QUERY, 0, 0, 0, 0, 0, 1).req, 0, none, 0);
    drain();

    // random phases: small tables so queries stay short
    for (int ph = 0; ph < 8; ph++) begin
      set_terms(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)),
                (ph == 7) ? 18'(262143) : 18'($urandom_range(0, 90000)));
      send(rand_req(KIND_CLEAR, 0), 0, none, 0);
      for (int j = 0; j < 60; j++) begin
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) k = KIND_LOAD;
        else if (r < 90) k = KIND_QUERY;
        else if (r < 95) k = KIND_CLEAR;
        else k = KIND_NONE;
        send(rand_req(k, $urandom_range(0, 9) != 0), 0, none,
             (j % 20 < 10) ? 0 : $urandom_range(0, 11));
        if (j == 30) while (pending.size() != 0) @(posedge clk);
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #200ms;
    $display("== FAIL ==");
    $finish;
  end
endmodule
